// File: design/gdo_pkg.sv
package gdo_pkg;

  // Field widths of one item
  localparam int YEAR_W  = 14;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int OFF_W   = 13;
  localparam int WDAY_W  = 3;

  // Working widths: signed day accumulator and signed year
  localparam int ACC_W = 15;
  localparam int YR_W  = 16;

  // Offset saturation is done at this width
  localparam int SAT_W = 18;

  // Calendar bounds
  localparam logic [YEAR_W-1:0]  YEAR_MIN  = 14'd1;
  localparam logic [YEAR_W-1:0]  YEAR_MAX  = 14'd9999;
  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;
  localparam logic [DAY_W-1:0]   DAY_LEAP  = 5'd29;

  // Reciprocals for division by constants
  // floor(x / 25) = (x * 5243) >> 17 for x below 43690
  localparam logic [12:0] RECIP25    = 13'd5243;
  localparam int          RECIP25_SH = 17;
  // floor(v / 7) = (v * 18725) >> 17 for v below 43690
  localparam logic [14:0] RECIP7     = 15'd18725;
  localparam int          RECIP7_SH  = 17;

  // Entries in the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // One classified item
  typedef struct packed {
    logic [YEAR_W-1:0]       year;
    logic [MONTH_W-1:0]      month;
    logic signed [ACC_W-1:0] day;
    logic                    feb_fix;
  } gdo_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LEAP_Q,
    ST_LEAP_SET,
    ST_STEP,
    ST_SAT,
    ST_WK_DIV,
    ST_WK_SUM,
    ST_WK_MUL,
    ST_WK_MOD
  } gdo_state_t;

  // Length of a month; February follows the leap flag
  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] len;
    case (m)
      4'd2:                   len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
      default:                len = 5'd31;
    endcase
    return len;
  endfunction

  // floor(3 * (m + 1) / 5) for the shifted month 3..14
  function automatic logic [3:0] month_adj(input logic [MONTH_W-1:0] ma);
    logic [3:0] adj;
    case (ma)
      4'd3:         adj = 4'd2;
      4'd4, 4'd5:   adj = 4'd3;
      4'd6, 4'd7:   adj = 4'd4;
      4'd8:         adj = 4'd5;
      4'd9, 4'd10:  adj = 4'd6;
      4'd11, 4'd12: adj = 4'd7;
      4'd13:        adj = 4'd8;
      4'd14:        adj = 4'd9;
      default:      adj = 4'd0;
    endcase
    return adj;
  endfunction

endpackage

// File: design/gdo_front.sv
module gdo_front import gdo_pkg::*; #(
  parameter int MAX_OFFSET = 4095
) (
  input  logic [YEAR_W-1:0]        year_in,
  input  logic [MONTH_W-1:0]       month_in,
  input  logic [DAY_W-1:0]         day_in,
  input  logic signed [OFF_W-1:0]  day_offset,
  output gdo_item_t                item
);

  localparam logic signed [SAT_W-1:0] OFF_HI = SAT_W'(MAX_OFFSET);
  localparam logic signed [SAT_W-1:0] OFF_LO = -SAT_W'(MAX_OFFSET);

  logic [YEAR_W-1:0]       year_c;
  logic [MONTH_W-1:0]      month_c;
  logic [DAY_W-1:0]        len_c;
  logic [DAY_W-1:0]        day_c;
  logic signed [SAT_W-1:0] off_wide;
  logic signed [SAT_W-1:0] off_sat;

  // Clamp year and month into range
  always_comb begin
    if (year_in < YEAR_MIN) begin
      year_c = YEAR_MIN;
    end else if (year_in > YEAR_MAX) begin
      year_c = YEAR_MAX;
    end else begin
      year_c = year_in;
    end
    if (month_in < MONTH_JAN) begin
      month_c = MONTH_JAN;
    end else if (month_in > MONTH_DEC) begin
      month_c = MONTH_DEC;
    end else begin
      month_c = month_in;
    end
  end

  // Clamp day; February allows 29 here, the back end trims it once the leap flag is known
  always_comb begin
    len_c = month_len(month_c, 1'b1);
    if (day_in == '0) begin
      day_c = 5'd1;
    end else if (day_in > len_c) begin
      day_c = len_c;
    end else begin
      day_c = day_in;
    end
  end

  // Saturate the offset
  always_comb begin
    off_wide = SAT_W'(day_offset);
    if (off_wide > OFF_HI) begin
      off_sat = OFF_HI;
    end else if (off_wide < OFF_LO) begin
      off_sat = OFF_LO;
    end else begin
      off_sat = off_wide;
    end
  end

  // Build the classified item
  always_comb begin
    item.year    = year_c;
    item.month   = month_c;
    item.day     = signed'(ACC_W'(day_c)) + ACC_W'(off_sat);
    item.feb_fix = (month_c == MONTH_FEB) && (day_c == DAY_LEAP);
  end

endmodule

// File: design/gdo_queue.sv
module gdo_queue import gdo_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  gdo_item_t push_item,
  input  logic      pop,
  output gdo_item_t head,
  output logic      full,
  output logic      empty
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  gdo_item_t        slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full  = (count == CNT_W'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  // Store pushed items
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: design/gdo_back.sv
module gdo_back import gdo_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  gdo_item_t          head,
  input  logic               empty,
  output logic               pop,
  output logic               done,
  output logic [YEAR_W-1:0]  year_out,
  output logic [MONTH_W-1:0] month_out,
  output logic [DAY_W-1:0]   day_out,
  output logic [WDAY_W-1:0]  weekday,
  output logic               last_of_month,
  output logic               range_error
);

  gdo_state_t state;
  gdo_state_t state_next;

  logic signed [YR_W-1:0]  y;
  logic [MONTH_W-1:0]      m;
  logic signed [ACC_W-1:0] d;
  logic                    fix;
  logic                    leap;
  logic [7:0]              q_leap;
  logic                    err;
  logic                    last;

  logic [YEAR_W-1:0]       ya;
  logic [MONTH_W-1:0]      ma;
  logic [7:0]              q100;
  logic [4:0]              q400;
  logic [13:0]             v;
  logic [10:0]             q7;

  // Step decisions
  logic [DAY_W-1:0]        dim;
  logic [MONTH_W-1:0]      m_prev;
  logic [DAY_W-1:0]        dim_prev;
  logic                    fwd;
  logic                    bwd;
  logic                    yr_lo;
  logic                    yr_hi;
  logic [24:0]             p_leap;
  logic [15:0]             q_leap_x100;
  logic                    leap_c;

  // Weekday arithmetic
  logic [YEAR_W-1:0]       ya_c;
  logic [MONTH_W-1:0]      ma_c;
  logic [24:0]             p100;
  logic [24:0]             p400;
  logic [14:0]             v_c;
  logic [28:0]             p7;
  logic [13:0]             wd_c;

  always_comb begin
    dim      = month_len(m, leap);
    m_prev   = (m == MONTH_JAN) ? MONTH_DEC : m - 1'b1;
    dim_prev = month_len(m_prev, leap);
    fwd      = d > signed'(ACC_W'(dim));
    bwd      = d < signed'(ACC_W'(1));
    yr_lo    = y < signed'(YR_W'(YEAR_MIN));
    yr_hi    = y > signed'(YR_W'(YEAR_MAX));
  end

  // Leap flag: divisible by 4, and not by 100 unless by 400
  always_comb begin
    p_leap      = 25'(y[13:2]) * 25'(RECIP25);
    q_leap_x100 = 16'(q_leap) * 16'd100;
    leap_c      = (y[1:0] == 2'b00) &&
                  ((q_leap_x100 != 16'(y[13:0])) || (q_leap[1:0] == 2'b00));
  end

  // Kim Larsen weekday terms
  always_comb begin
    if (m <= MONTH_FEB) begin
      ya_c = y[13:0] - 1'b1;
      ma_c = m + 4'd12;
    end else begin
      ya_c = y[13:0];
      ma_c = m;
    end
    p100 = 25'(ya_c[13:2]) * 25'(RECIP25);
    p400 = 25'(ya_c[13:4]) * 25'(RECIP25);
    v_c  = 15'(d[DAY_W-1:0]) + 15'({ma, 1'b0}) + 15'(month_adj(ma)) + 15'(ya)
           + 15'(ya[13:2]) - 15'(q100) + 15'(q400);
    p7   = 29'(v) * 29'(RECIP7);
    wd_c = v - 14'({q7, 3'b000}) + 14'(q7);
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (!empty) state_next = ST_LEAP_Q;
      end
      ST_LEAP_Q:   state_next = ST_LEAP_SET;
      ST_LEAP_SET: state_next = ST_STEP;
      ST_STEP: begin
        if (fwd) begin
          state_next = (m == MONTH_DEC) ? ST_LEAP_Q : ST_STEP;
        end else if (bwd) begin
          state_next = (m == MONTH_JAN) ? ST_LEAP_Q : ST_STEP;
        end else begin
          state_next = ST_SAT;
        end
      end
      ST_SAT:    state_next = ST_WK_DIV;
      ST_WK_DIV: state_next = ST_WK_SUM;
      ST_WK_SUM: state_next = ST_WK_MUL;
      ST_WK_MUL: state_next = ST_WK_MOD;
      ST_WK_MOD: state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // Outputs to the queue
  always_comb begin
    pop = (state == ST_IDLE) && !empty;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == ST_WK_MOD);
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        y   <= signed'(YR_W'(head.year));
        m   <= head.month;
        d   <= head.day;
        fix <= head.feb_fix;
      end
      ST_LEAP_Q: begin
        q_leap <= p_leap[24:RECIP25_SH];
      end
      ST_LEAP_SET: begin
        leap <= leap_c;
        fix  <= 1'b0;
        // Trim a clamped 29 February in a common year
        if (fix && !leap_c) begin
          d <= d - 1'b1;
        end
      end
      ST_STEP: begin
        if (fwd) begin
          d <= d - signed'(ACC_W'(dim));
          if (m == MONTH_DEC) begin
            m <= MONTH_JAN;
            y <= y + 1'b1;
          end else begin
            m <= m + 1'b1;
          end
        end else if (bwd) begin
          d <= d + signed'(ACC_W'(dim_prev));
          m <= m_prev;
          if (m == MONTH_JAN) begin
            y <= y - 1'b1;
          end
        end
      end
      ST_SAT: begin
        err <= yr_lo || yr_hi;
        if (yr_lo) begin
          y    <= signed'(YR_W'(YEAR_MIN));
          m    <= MONTH_JAN;
          d    <= signed'(ACC_W'(1));
          last <= 1'b0;
        end else if (yr_hi) begin
          y    <= signed'(YR_W'(YEAR_MAX));
          m    <= MONTH_DEC;
          d    <= signed'(ACC_W'(31));
          last <= 1'b1;
        end else begin
          last <= (d == signed'(ACC_W'(dim)));
        end
      end
      ST_WK_DIV: begin
        ya   <= ya_c;
        ma   <= ma_c;
        q100 <= p100[24:RECIP25_SH];
        q400 <= p400[21:RECIP25_SH];
      end
      ST_WK_SUM: begin
        v <= v_c[13:0];
      end
      ST_WK_MUL: begin
        q7 <= p7[27:RECIP7_SH];
      end
      ST_WK_MOD: begin
        year_out      <= y[YEAR_W-1:0];
        month_out     <= m;
        day_out       <= d[DAY_W-1:0];
        weekday       <= wd_c[WDAY_W-1:0];
        last_of_month <= last;
        range_error   <= err;
      end
      default: begin
      end
    endcase
  end

endmodule

// File: design/gregorian_date_offset.sv
// From acceptance to done an item passes the leap check, the month-stepping loop,
// saturation and the weekday steps; the loop steps one month at a time, and each year
// crossed repeats the leap check. The back end takes one item at a time into the loop;
// a two-entry queue takes further items while busy is low. The receiver cannot stall: done
// is high for one cycle per item. Synchronous active-high reset empties the queue and idles.
module gregorian_date_offset import gdo_pkg::*; #(
  parameter int MAX_OFFSET = 4095
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic [YEAR_W-1:0]       year_in,
  input  logic [MONTH_W-1:0]      month_in,
  input  logic [DAY_W-1:0]        day_in,
  input  logic signed [OFF_W-1:0] day_offset,
  output logic                    done,
  output logic [YEAR_W-1:0]       year_out,
  output logic [MONTH_W-1:0]      month_out,
  output logic [DAY_W-1:0]        day_out,
  output logic [WDAY_W-1:0]       weekday,
  output logic                    last_of_month,
  output logic                    range_error
);

  gdo_item_t item;
  gdo_item_t head;
  logic      push;
  logic      pop;
  logic      full;
  logic      empty;

  assign busy = full;
  assign push = start && !full;

  // Clamp and classify
  gdo_front #(
    .MAX_OFFSET (MAX_OFFSET)
  ) u_front (
    .year_in    (year_in),
    .month_in   (month_in),
    .day_in     (day_in),
    .day_offset (day_offset),
    .item       (item)
  );

  // Hold items between front and back
  gdo_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (item),
    .pop       (pop),
    .head      (head),
    .full      (full),
    .empty     (empty)
  );

  // Step months and work out the weekday
  gdo_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (head),
    .empty         (empty),
    .pop           (pop),
    .done          (done),
    .year_out      (year_out),
    .month_out     (month_out),
    .day_out       (day_out),
    .weekday       (weekday),
    .last_of_month (last_of_month),
    .range_error   (range_error)
  );

endmodule
